FILE: rtl/dkwe_pkg.sv
`default_nettype none

package dkwe_pkg;

    localparam int unsigned NumCells     = 32;
    localparam int unsigned CodeW        = 2;
    localparam int unsigned KmerW        = NumCells * CodeW;
    localparam int unsigned WidthW       = 6;
    localparam int unsigned FillW        = 6;

    localparam logic [WidthW-1:0] WidthReset = 6'd16;
    localparam logic [WidthW-1:0] WidthMax   = 6'd32;
    localparam logic [FillW-1:0]  FillSat    = 6'd63;

    localparam logic [7:0] CharA = 8'h41;
    localparam logic [7:0] CharC = 8'h43;
    localparam logic [7:0] CharG = 8'h47;
    localparam logic [7:0] CharT = 8'h54;

    typedef struct packed {
        logic [7:0] base_char;
        logic       seq_start;
    } in_t;

    typedef struct packed {
        logic [KmerW-1:0] kmer_value;
        logic             is_reverse;
        logic             last;
    } out_t;

    // Shared by all cells in one cycle.
    typedef struct packed {
        logic             advance;
        logic [CodeW-1:0] rcode;
    } cell_ctrl_t;

    // Forward code in [3:2], complement code in [1:0]; unknown gives zeros.
    function automatic logic [2*CodeW-1:0] decode_base(input logic [7:0] ch);
        logic [2*CodeW-1:0] codes;
        case (ch)
            CharA:   codes = 4'b00_11;
            CharC:   codes = 4'b01_10;
            CharG:   codes = 4'b10_01;
            CharT:   codes = 4'b11_00;
            default: codes = 4'b00_00;
        endcase
        return codes;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dkwe_cell.sv
`default_nettype none

module dkwe_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dkwe_pkg::cell_ctrl_t          ctrl,
    input  wire logic [dkwe_pkg::CodeW-1:0]    fwd_in,
    input  wire logic [dkwe_pkg::CodeW-1:0]    rc_in,
    input  wire logic                          active,
    input  wire logic                          is_top,
    output logic      [dkwe_pkg::CodeW-1:0]    fwd_q,
    output logic      [dkwe_pkg::CodeW-1:0]    rc_q
);

    logic [dkwe_pkg::CodeW-1:0] fwd_reg, fwd_next;
    logic [dkwe_pkg::CodeW-1:0] rc_reg,  rc_next;

    always_comb
    begin
        fwd_next = fwd_reg;
        rc_next  = rc_reg;
        if (ctrl.advance)
        begin
            // take neighbor data, insert complement at the top, drop outside window
            fwd_next = fwd_in & {dkwe_pkg::CodeW{active}};
            rc_next  = (rc_in | (ctrl.rcode & {dkwe_pkg::CodeW{is_top}}))
                       & {dkwe_pkg::CodeW{active}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rc_reg  <= '0;
        end
        else
        begin
            fwd_reg <= fwd_next;
            rc_reg  <= rc_next;
        end
    end

    assign fwd_q = fwd_reg;
    assign rc_q  = rc_reg;

endmodule

`default_nettype wire

FILE: rtl/dna_kmer_window_encoder.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (base_char, seq_start)
// out     | output    | out_valid / out_ready | out_data (kmer_value, is_reverse, last)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (window_width)
//
// A base that completes a window yields a pair: the forward transaction, then the
// reverse-complement transaction, both read straight from the cell row.
// A base that yields nothing gives no output. The single result port sets the pace.
// Reset clears both windows, the fill count and the output stage; width returns to 16.
// A stalled output holds the cell row; the next base enters on the cycle the
// reverse transaction is taken.
`default_nettype none

module dna_kmer_window_encoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire dkwe_pkg::in_t                   in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output dkwe_pkg::out_t                       out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dkwe_pkg::WidthW-1:0]     cfg_data
);

    localparam int unsigned N  = dkwe_pkg::NumCells;
    localparam int unsigned CW = dkwe_pkg::CodeW;

    // Configuration: window width in bases.
    logic [dkwe_pkg::WidthW-1:0] width_reg, width_next;
    logic [dkwe_pkg::WidthW-1:0] eff_width;
    logic [dkwe_pkg::WidthW-1:0] top_pos;

    // Sequence progress, saturating.
    logic [dkwe_pkg::FillW-1:0]  fill_reg, fill_next, fill_step;

    // Output stage: pending flag and which half of the pair is shown.
    logic                        out_valid_reg, out_valid_next;
    logic                        phase_reg, phase_next;

    logic                        in_acc;
    logic                        emit;
    logic [2*CW-1:0]             codes;
    dkwe_pkg::cell_ctrl_t        ctrl;

    logic [CW-1:0]               fwd_q   [N];
    logic [CW-1:0]               rc_q    [N];
    logic [CW-1:0]               fwd_in  [N];
    logic [CW-1:0]               rc_in   [N];
    logic [N-1:0]                active;
    logic [N-1:0]                is_top;
    logic [dkwe_pkg::KmerW-1:0]  fwd_vec;
    logic [dkwe_pkg::KmerW-1:0]  rc_vec;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next = width_reg;
        if (cfg_valid && cfg_ready)
        begin
            width_next = cfg_data;
        end
    end

    // Clamp the width to 1..32.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = dkwe_pkg::WidthW'(1);
        end
        else if (width_reg > dkwe_pkg::WidthMax)
        begin
            eff_width = dkwe_pkg::WidthMax;
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    assign top_pos = eff_width - dkwe_pkg::WidthW'(1);

    assign in_ready = !out_valid_reg || (phase_reg && out_ready);
    assign in_acc   = in_valid && in_ready;
    assign codes    = dkwe_pkg::decode_base(in_data.base_char);

    assign ctrl.advance = in_acc;
    assign ctrl.rcode   = codes[CW-1:0];

    // Fill count after this base: restart at one on a new sequence.
    always_comb
    begin
        if (fill_reg == dkwe_pkg::FillSat)
        begin
            fill_step = fill_reg;
        end
        else
        begin
            fill_step = fill_reg + dkwe_pkg::FillW'(1);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (in_acc)
        begin
            fill_next = in_data.seq_start ? dkwe_pkg::FillW'(1) : fill_step;
        end
    end

    assign emit = (in_data.seq_start ? dkwe_pkg::FillW'(1) : fill_step) >= eff_width;

    // Cell row: forward data moves up, complement data moves down.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == 0)
        begin : g_low
            assign fwd_in[i] = codes[2*CW-1:CW];
        end
        else
        begin : g_fwd
            assign fwd_in[i] = in_data.seq_start ? '0 : fwd_q[i-1];
        end

        if (i == N - 1)
        begin : g_high
            assign rc_in[i] = '0;
        end
        else
        begin : g_rc
            assign rc_in[i] = in_data.seq_start ? '0 : rc_q[i+1];
        end

        assign active[i] = dkwe_pkg::WidthW'(i) < eff_width;
        assign is_top[i] = dkwe_pkg::WidthW'(i) == top_pos;

        dkwe_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .fwd_in (fwd_in[i]),
            .rc_in  (rc_in[i]),
            .active (active[i]),
            .is_top (is_top[i]),
            .fwd_q  (fwd_q[i]),
            .rc_q   (rc_q[i])
        );

        assign fwd_vec[CW*i +: CW] = fwd_q[i];
        assign rc_vec[CW*i +: CW]  = rc_q[i];
    end

    // Output sequencing: forward first, then reverse; a new emitting base
    // restarts the pair on the same edge the reverse transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (out_valid_reg && out_ready)
        begin
            if (!phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (in_acc && emit)
        begin
            out_valid_next = 1'b1;
            phase_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= dkwe_pkg::WidthReset;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.kmer_value = phase_reg ? rc_vec : fwd_vec;
    assign out_data.is_reverse = phase_reg;
    assign out_data.last       = phase_reg;

endmodule

`default_nettype wire
